/* rtl/remote_position_motor_controller_macros.svh */
// ----------------------------------------------------------------------------
// Remote position motor controller assertion macros
// Shorthands for the concurrent checks in the controller, clocked on clock
// and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef REMOTE_POSITION_MOTOR_CONTROLLER_MACROS_SVH
`define REMOTE_POSITION_MOTOR_CONTROLLER_MACROS_SVH

// Same-cycle implication check.
`define RPMC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define RPMC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rpmc_pkg.sv */
// ----------------------------------------------------------------------------
// Remote position motor controller package
// Shared types, program and drive codes, and the remote code decoder.
// ----------------------------------------------------------------------------
package rpmc_pkg;

   // Program selections.
   localparam logic [4:0] PROG_NONE         = 5'd0;
   localparam logic [4:0] PROG_PRESET_FIRST = 5'd1;
   localparam logic [4:0] PROG_PRESET_LAST  = 5'd9;
   localparam logic [4:0] PROG_STOP         = 5'd10;
   localparam logic [4:0] PROG_BOTTOM       = 5'd11;
   localparam logic [4:0] PROG_TOP          = 5'd12;
   localparam logic [4:0] PROG_CYCLE        = 5'd13;
   localparam logic [4:0] PROG_LEFT         = 5'd14;
   localparam logic [4:0] PROG_DOWN         = 5'd15;
   localparam logic [4:0] PROG_RIGHT        = 5'd16;
   localparam logic [4:0] PROG_UP           = 5'd17;

   // Motor drive codes.
   localparam logic [1:0] DRV_BRAKE = 2'd0;
   localparam logic [1:0] DRV_UP    = 2'd1;
   localparam logic [1:0] DRV_DOWN  = 2'd2;

   // Remote command bytes.
   localparam logic [7:0] IR_PRESET1 = 8'h45;
   localparam logic [7:0] IR_PRESET2 = 8'h46;
   localparam logic [7:0] IR_PRESET3 = 8'h47;
   localparam logic [7:0] IR_PRESET4 = 8'h44;
   localparam logic [7:0] IR_PRESET5 = 8'h40;
   localparam logic [7:0] IR_PRESET6 = 8'h43;
   localparam logic [7:0] IR_PRESET7 = 8'h07;
   localparam logic [7:0] IR_PRESET8 = 8'h15;
   localparam logic [7:0] IR_PRESET9 = 8'h09;
   localparam logic [7:0] IR_STOP    = 8'h19;
   localparam logic [7:0] IR_BOTTOM  = 8'h16;
   localparam logic [7:0] IR_TOP     = 8'h0D;
   localparam logic [7:0] IR_CYCLE   = 8'h1C;
   localparam logic [7:0] IR_LEFT    = 8'h08;
   localparam logic [7:0] IR_DOWN    = 8'h52;
   localparam logic [7:0] IR_RIGHT   = 8'h5A;
   localparam logic [7:0] IR_UP      = 8'h18;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FULL_TRAVEL = 2'd0;
   localparam logic [1:0] CSR_PRESET_STEP = 2'd1;
   localparam logic [1:0] CSR_TOLERANCE   = 2'd2;
   localparam logic [1:0] CSR_PAUSE_MS    = 2'd3;

   // Configuration reset values.
   localparam logic [14:0] FULL_TRAVEL_RST = 15'd1430;
   localparam logic [14:0] PRESET_STEP_RST = 15'd143;
   localparam logic [9:0]  TOLERANCE_RST   = 10'd14;
   localparam logic [15:0] PAUSE_MS_RST    = 16'd300;

   typedef struct packed {
      logic [14:0] full_travel;
      logic [14:0] preset_step;
      logic [9:0]  tolerance;
      logic [15:0] pause_ms;
   } cfg_type;

   typedef struct packed {
      logic       enc_a;
      logic       enc_b;
      logic       ir_valid;
      logic [7:0] ir_code;
      logic       ms_tick;
   } item_type;

   typedef struct packed {
      logic [15:0] position;
      logic [15:0] target;
      logic        last_a;
      logic [4:0]  prog;
      logic [1:0]  drive;
      logic        pause_pending;
      logic [15:0] pause_left;
   } state_type;

   typedef struct packed {
      logic [1:0]  drive;
      logic [15:0] position;
      logic [15:0] target;
      logic        at_target;
   } result_type;

   // Maps a remote command byte to a program; unknown bytes give PROG_NONE.
   function automatic logic [4:0] decode_code(input logic [7:0] code);
      logic [4:0] prog;
      unique case (code)
         IR_PRESET1: prog = 5'd1;
         IR_PRESET2: prog = 5'd2;
         IR_PRESET3: prog = 5'd3;
         IR_PRESET4: prog = 5'd4;
         IR_PRESET5: prog = 5'd5;
         IR_PRESET6: prog = 5'd6;
         IR_PRESET7: prog = 5'd7;
         IR_PRESET8: prog = 5'd8;
         IR_PRESET9: prog = 5'd9;
         IR_STOP:    prog = PROG_STOP;
         IR_BOTTOM:  prog = PROG_BOTTOM;
         IR_TOP:     prog = PROG_TOP;
         IR_CYCLE:   prog = PROG_CYCLE;
         IR_LEFT:    prog = PROG_LEFT;
         IR_DOWN:    prog = PROG_DOWN;
         IR_RIGHT:   prog = PROG_RIGHT;
         IR_UP:      prog = PROG_UP;
         default:    prog = PROG_NONE;
      endcase
      return prog;
   endfunction

endpackage

/* rtl/rpmc_csr.sv */
// ----------------------------------------------------------------------------
// Remote position motor controller configuration registers
// Holds the four settings and takes one register write per beat.
// ----------------------------------------------------------------------------
module rpmc_csr
   import rpmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [1:0]  wr_index,
   input  logic [15:0] wr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_FULL_TRAVEL: cfg_in.full_travel = wr_data[14:0];
            CSR_PRESET_STEP: cfg_in.preset_step = wr_data[14:0];
            CSR_TOLERANCE:   cfg_in.tolerance   = wr_data[9:0];
            CSR_PAUSE_MS:    cfg_in.pause_ms    = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_travel <= FULL_TRAVEL_RST;
         cfg_ff.preset_step <= PRESET_STEP_RST;
         cfg_ff.tolerance   <= TOLERANCE_RST;
         cfg_ff.pause_ms    <= PAUSE_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/rpmc_step.sv */
// ----------------------------------------------------------------------------
// Remote position motor controller step logic
// Computes the next controller state and the result of one sample tick.
// ----------------------------------------------------------------------------
module rpmc_step
   import rpmc_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  cur,
   input  item_type   item,
   output state_type  nxt,
   output result_type res
);

   logic [15:0]        pos;
   logic signed [16:0] diff;
   logic signed [16:0] tol_s;
   logic               at_raw;
   logic               at;
   logic [4:0]         dec;
   logic [4:0]         prog;
   logic [4:0]         prog_next;
   logic [16:0]        nudge;
   logic signed [17:0] pos_wide;
   logic signed [17:0] nudge_dn;
   logic signed [17:0] nudge_up;
   logic [18:0]        preset_prod;
   logic [15:0]        preset_tgt;
   logic [15:0]        tgt;
   logic [15:0]        tgt_out;
   logic               pend;
   logic [15:0]        left;
   logic [1:0]         drv;

   always_comb begin
      // Encoder counts on a rising edge of line A.
      pos = cur.position;
      if (item.enc_a && !cur.last_a) begin
         pos = item.enc_b ? cur.position - 16'd1 : cur.position + 16'd1;
      end

      diff   = $signed({cur.target[15], cur.target}) - $signed({pos[15], pos});
      tol_s  = $signed({7'd0, cfg.tolerance});
      at_raw = (diff >= -tol_s) && (diff <= tol_s);

      dec  = decode_code(item.ir_code);
      prog = (item.ir_valid && (dec != PROG_NONE)) ? dec : cur.prog;

      // Nudge distance is one or two preset steps.
      nudge    = ((prog == PROG_DOWN) || (prog == PROG_UP)) ?
                 {1'b0, cfg.preset_step, 1'b0} : {2'b00, cfg.preset_step};
      pos_wide = $signed({{2{pos[15]}}, pos});
      nudge_dn = pos_wide - $signed({1'b0, nudge});
      nudge_up = pos_wide + $signed({1'b0, nudge});

      preset_prod = {15'd0, prog[3:0]} * {4'd0, cfg.preset_step};
      preset_tgt  = (|preset_prod[18:15]) ? 16'h7FFF : {1'b0, preset_prod[14:0]};

      tgt       = cur.target;
      at        = at_raw;
      prog_next = prog;
      pend      = cur.pause_pending;
      left      = cur.pause_left;

      unique case (prog) inside
         PROG_TOP:    tgt = {1'b0, cfg.full_travel};
         PROG_BOTTOM: tgt = 16'd0;
         PROG_STOP: begin
            at  = 1'b1;
            tgt = pos;
         end
         PROG_CYCLE: begin
            if (at_raw && !cur.pause_pending) begin
               pend = 1'b1;
               left = cfg.pause_ms;
            end
         end
         PROG_LEFT, PROG_DOWN: begin
            if (at_raw) begin
               tgt = nudge_dn[17] ? 16'd0 : nudge_dn[15:0];
            end
            prog_next = PROG_NONE;
         end
         PROG_RIGHT, PROG_UP: begin
            if (at_raw) begin
               tgt = (nudge_up > $signed({3'd0, cfg.full_travel})) ?
                     {1'b0, cfg.full_travel} : nudge_up[15:0];
            end
            prog_next = PROG_NONE;
         end
         [PROG_PRESET_FIRST:PROG_PRESET_LAST]: tgt = preset_tgt;
         default: prog_next = PROG_NONE;
      endcase

      // Drive follows the program's target, before any pause expiry.
      if (at) begin
         drv = DRV_BRAKE;
      end else if ($signed(pos) < $signed(tgt)) begin
         drv = ($signed(pos) >= $signed({1'b0, cfg.full_travel})) ? DRV_BRAKE : DRV_UP;
      end else if ($signed(pos) > $signed(16'd0)) begin
         drv = DRV_DOWN;
      end else begin
         drv = cur.drive;
      end

      // A pause armed in an earlier tick counts down here; at its end the
      // target flips between the two ends of travel.
      tgt_out = tgt;
      if (cur.pause_pending && item.ms_tick) begin
         if (cur.pause_left <= 16'd1) begin
            left    = 16'd0;
            pend    = 1'b0;
            tgt_out = ($signed(tgt) <= $signed({6'd0, cfg.tolerance})) ?
                      {1'b0, cfg.full_travel} : 16'd0;
         end else begin
            left = cur.pause_left - 16'd1;
         end
      end

      nxt.position      = pos;
      nxt.target        = tgt_out;
      nxt.last_a        = item.enc_a;
      nxt.prog          = prog_next;
      nxt.drive         = drv;
      nxt.pause_pending = pend;
      nxt.pause_left    = left;

      res.drive     = drv;
      res.position  = pos;
      res.target    = tgt_out;
      res.at_target = at;
   end

endmodule

/* rtl/remote_position_motor_controller.sv */
// ----------------------------------------------------------------------------
// Remote position motor controller
// Encoder counting, remote program selection and motor drive per sample tick.
// ----------------------------------------------------------------------------
// Each req beat is one sample tick carrying the encoder levels, an optional
// decoded remote code and a millisecond flag; each tick yields exactly one
// rsp beat with the motor drive, the position after counting, the target and
// the at-target flag. A beat is captured in an input register, the whole
// update is done by the step logic once the output register is free or is
// being emptied, and the result lands in an output register. One beat is
// accepted every cycle while rsp_tready is high; the single step stage,
// which reads and writes the controller state in the same cycle, sets that
// rate of one tick per cycle. When the output register holds a result that
// has not been taken, the input register still takes one more beat before
// req_tready drops. Configuration writes are always ready and take effect
// on the next cycle; they must be made only while no tick is in flight.
// ----------------------------------------------------------------------------
`include "remote_position_motor_controller_macros.svh"

module remote_position_motor_controller
   import rpmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Sample tick stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] enc_a, [1] enc_b, [2] ir_valid, [10:3] ir_code, [11] ms_tick, rest zero
   input  logic [15:0] req_tdata,
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] drive, [17:2] position, [33:18] target, [34] at_target, rest zero
   output logic [39:0] rsp_tdata,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   state_type  state_ff, state_nxt;
   result_type step_res;
   logic       fire;
   logic       req_beat;

   assign csr_ready = 1'b1;

   rpmc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   rpmc_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_nxt),
      .res  (step_res)
   );

   // The step runs when a tick is held and the output register is free or
   // being emptied in this cycle.
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      item_in.enc_a    = req_tdata[0];
      item_in.enc_b    = req_tdata[1];
      item_in.ir_valid = req_tdata[2];
      item_in.ir_code  = req_tdata[10:3];
      item_in.ms_tick  = req_tdata[11];
   end

   assign in_valid_in  = req_beat ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         state_ff.position       <= 16'd0;
         state_ff.target         <= 16'd0;
         state_ff.last_a         <= 1'b0;
         state_ff.prog           <= PROG_NONE;
         state_ff.drive          <= DRV_BRAKE;
         state_ff.pause_pending  <= 1'b0;
         state_ff.pause_left     <= 16'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_nxt;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff <= item_in;
      end
      if (fire) begin
         out_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.at_target, out_ff.target, out_ff.position, out_ff.drive};

   // A result flagged at target always brakes the motor.
   `RPMC_ASSERT_IMP(a_at_target_brakes, rsp_tvalid && out_ff.at_target, out_ff.drive == DRV_BRAKE, "at target without brake")

   // The pause counter is idle at zero whenever no pause is pending.
   `RPMC_ASSERT_IMP(a_pause_idle, !state_ff.pause_pending, state_ff.pause_left == 16'd0, "pause count without pending pause")

   // One tick moves the position by at most one pulse.
   `RPMC_ASSERT_NXT(a_position_step, fire, (state_ff.position == $past(state_ff.position)) || (state_ff.position == $past(state_ff.position) + 16'd1) || (state_ff.position == $past(state_ff.position) - 16'd1), "position jumped")

   // One-shot nudges never survive past the tick that ran them.
   `RPMC_ASSERT_IMP(a_no_stored_nudge, in_valid_ff, state_ff.prog <= PROG_CYCLE, "nudge program left selected")

endmodule
